[design/jse_pkg.sv]
// Shared types, character codes and helpers for the JSON string escaper.
package jse_pkg;

  localparam int unsigned MaxOut = 10;  // most bytes one request can produce
  localparam int unsigned LenW   = 4;   // holds 0..MaxOut

  typedef logic [LenW-1:0] len_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       has_byte;
    logic       first;
    logic       last;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_run;
  } out_req_t;

  // One classified request: its output text, byte 0 goes out first.
  typedef struct packed {
    logic [MaxOut-1:0][7:0] text;
    len_t                   len;
  } job_t;

  // Queue write side seen by the front end.
  typedef struct packed {
    logic push;
    job_t job;
  } jse_push_t;

  // Held UTF-8 prefix of a line or paragraph separator.
  typedef enum logic [2:0] {
    HeldNone = 3'b001,
    HeldE2   = 3'b010,
    HeldE280 = 3'b100
  } held_t;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChLowU   = 8'h75;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChTwo    = 8'h32;
  localparam logic [7:0] ChEight  = 8'h38;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChLowB   = 8'h62;
  localparam logic [7:0] ChLowF   = 8'h66;
  localparam logic [7:0] ChLowN   = 8'h6e;
  localparam logic [7:0] ChLowR   = 8'h72;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] ChBs     = 8'h08;
  localparam logic [7:0] ChFf     = 8'h0c;
  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] CtrlMax  = 8'h1f;
  localparam logic [7:0] Utf8Lead = 8'he2;
  localparam logic [7:0] Utf8Mid  = 8'h80;
  localparam logic [7:0] Utf8Ls   = 8'ha8;
  localparam logic [7:0] Utf8Ps   = 8'ha9;

  // Lower-case hex digit.
  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = 8'h30 + {4'h0, d};
    end else begin
      r = 8'h57 + {4'h0, d};
    end
    return r;
  endfunction

endpackage

[design/json_string_escaper.sv]
// Top level of the JSON string escaper: front end, request queue, back end.
//
//   channel | direction | handshake           | request type
//   in      | input     | in_valid / in_stall  | jse_pkg::in_req_t
//   out     | output    | out_valid / out_stall| jse_pkg::out_req_t
//
// The back end sends one output byte per cycle unless stalled; a request that
// yields no bytes is never queued and takes no back-end time.
// Input is taken every cycle while the two-entry queue has room, so plain text
// runs at one byte per cycle; with the queue and output register free, an accepted
// request is written to the queue and then its first byte to the output register.
// Reset (rst, synchronous) empties the queue, drops the held prefix and out_valid.
// out_stall freezes the output register; the queue then fills and raises in_stall.
module json_string_escaper (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  jse_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output jse_pkg::out_req_t out_req
);

  jse_pkg::jse_push_t wr;
  jse_pkg::job_t      head;
  logic               full;
  logic               head_valid;
  logic               pop;

  jse_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_req   (in_req),
    .full     (full),
    .in_stall (in_stall),
    .wr       (wr)
  );

  jse_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr         (wr),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  jse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_req    (out_req)
  );

endmodule

[design/jse_front.sv]
// Front end: takes input requests, tracks the held prefix, builds the output text.
module jse_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  jse_pkg::in_req_t in_req,
  input  logic             full,
  output logic             in_stall,
  output jse_pkg::jse_push_t wr
);

  jse_pkg::held_t held;
  jse_pkg::held_t h1, h2, held_next;

  logic [2:0][7:0] pre_txt;
  jse_pkg::len_t   pre_len;
  logic [5:0][7:0] pl_txt;
  jse_pkg::len_t   pl_len;
  logic            pl_hold;
  logic [7:0][7:0] mid_txt;
  jse_pkg::len_t   mid_len;
  logic [1:0]      fl;
  logic            use_plain;
  logic [2:0][7:0] post_txt;
  jse_pkg::len_t   post_len;
  jse_pkg::len_t   pm_len;
  logic [7:0]      b;

  assign b        = in_req.in_byte;
  assign in_stall = full;

  // Opening quote, after flushing any prefix left from an unterminated string.
  always_comb begin
    pre_txt = '0;
    pre_len = '0;
    h1      = held;
    if (in_req.first) begin
      h1 = jse_pkg::HeldNone;
      unique case (held)
        jse_pkg::HeldE2: begin
          pre_txt = {8'h00, jse_pkg::ChQuote, jse_pkg::Utf8Lead};
          pre_len = jse_pkg::len_t'(2);
        end
        jse_pkg::HeldE280: begin
          pre_txt = {jse_pkg::ChQuote, jse_pkg::Utf8Mid, jse_pkg::Utf8Lead};
          pre_len = jse_pkg::len_t'(3);
        end
        default: begin
          pre_txt = {16'h0000, jse_pkg::ChQuote};
          pre_len = jse_pkg::len_t'(1);
        end
      endcase
    end
  end

  // Escape of one byte with nothing held.
  always_comb begin
    pl_txt  = '0;
    pl_len  = '0;
    pl_hold = 1'b0;
    case (b)
      jse_pkg::ChBslash: begin
        pl_txt = {32'h0, jse_pkg::ChBslash, jse_pkg::ChBslash};
        pl_len = jse_pkg::len_t'(2);
      end
      jse_pkg::ChQuote: begin
        pl_txt = {32'h0, jse_pkg::ChQuote, jse_pkg::ChBslash};
        pl_len = jse_pkg::len_t'(2);
      end
      jse_pkg::ChBs: begin
        pl_txt = {32'h0, jse_pkg::ChLowB, jse_pkg::ChBslash};
        pl_len = jse_pkg::len_t'(2);
      end
      jse_pkg::ChFf: begin
        pl_txt = {32'h0, jse_pkg::ChLowF, jse_pkg::ChBslash};
        pl_len = jse_pkg::len_t'(2);
      end
      jse_pkg::ChLf: begin
        pl_txt = {32'h0, jse_pkg::ChLowN, jse_pkg::ChBslash};
        pl_len = jse_pkg::len_t'(2);
      end
      jse_pkg::ChCr: begin
        pl_txt = {32'h0, jse_pkg::ChLowR, jse_pkg::ChBslash};
        pl_len = jse_pkg::len_t'(2);
      end
      jse_pkg::ChTab: begin
        pl_txt = {32'h0, jse_pkg::ChLowT, jse_pkg::ChBslash};
        pl_len = jse_pkg::len_t'(2);
      end
      jse_pkg::Utf8Lead: begin
        pl_hold = 1'b1;
      end
      default: begin
        if (b <= jse_pkg::CtrlMax) begin
          pl_txt = {jse_pkg::hex_char(b[3:0]), jse_pkg::hex_char(b[7:4]),
                    jse_pkg::ChZero, jse_pkg::ChZero, jse_pkg::ChLowU, jse_pkg::ChBslash};
          pl_len = jse_pkg::len_t'(6);
        end else begin
          pl_txt = {40'h0, b};
          pl_len = jse_pkg::len_t'(1);
        end
      end
    endcase
  end

  // Byte against the held prefix.
  always_comb begin
    mid_txt   = '0;
    mid_len   = '0;
    h2        = h1;
    fl        = 2'd0;
    use_plain = 1'b0;
    if (in_req.has_byte) begin
      use_plain = 1'b1;
      unique case (h1)
        jse_pkg::HeldE280: begin
          if (b == jse_pkg::Utf8Ls || b == jse_pkg::Utf8Ps) begin
            use_plain = 1'b0;
            mid_txt = {16'h0, ((b == jse_pkg::Utf8Ls) ? jse_pkg::ChEight : jse_pkg::ChNine),
                       jse_pkg::ChTwo, jse_pkg::ChZero, jse_pkg::ChTwo,
                       jse_pkg::ChLowU, jse_pkg::ChBslash};
            mid_len = jse_pkg::len_t'(6);
            h2      = jse_pkg::HeldNone;
          end else begin
            fl = 2'd2;
          end
        end
        jse_pkg::HeldE2: begin
          if (b == jse_pkg::Utf8Mid) begin
            use_plain = 1'b0;
            h2        = jse_pkg::HeldE280;
          end else begin
            fl = 2'd1;
          end
        end
        default: begin
          fl = 2'd0;
        end
      endcase
      if (use_plain) begin
        // broken prefix goes out raw ahead of the byte's own text
        mid_txt = {16'h0, pl_txt} << {fl, 3'b000};
        if (fl != 2'd0) begin
          mid_txt[0] = jse_pkg::Utf8Lead;
        end
        if (fl == 2'd2) begin
          mid_txt[1] = jse_pkg::Utf8Mid;
        end
        mid_len = jse_pkg::len_t'(pl_len + {2'b00, fl});
        h2      = pl_hold ? jse_pkg::HeldE2 : jse_pkg::HeldNone;
      end
    end
  end

  // Closing quote, after flushing what is still held.
  always_comb begin
    post_txt  = '0;
    post_len  = '0;
    held_next = h2;
    if (in_req.last) begin
      held_next = jse_pkg::HeldNone;
      unique case (h2)
        jse_pkg::HeldE2: begin
          post_txt = {8'h00, jse_pkg::ChQuote, jse_pkg::Utf8Lead};
          post_len = jse_pkg::len_t'(2);
        end
        jse_pkg::HeldE280: begin
          post_txt = {jse_pkg::ChQuote, jse_pkg::Utf8Mid, jse_pkg::Utf8Lead};
          post_len = jse_pkg::len_t'(3);
        end
        default: begin
          post_txt = {16'h0000, jse_pkg::ChQuote};
          post_len = jse_pkg::len_t'(1);
        end
      endcase
    end
  end

  assign pm_len = jse_pkg::len_t'(pre_len + mid_len);

  always_comb begin
    wr.job.text = {56'h0, pre_txt}
                | ({16'h0, mid_txt} << {pre_len, 3'b000})
                | ({56'h0, post_txt} << {pm_len, 3'b000});
    wr.job.len  = jse_pkg::len_t'(pm_len + post_len);
    wr.push     = in_valid && !full && (wr.job.len != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= jse_pkg::HeldNone;
    end else if (in_valid && !full) begin
      held <= held_next;
    end
  end

endmodule

[design/jse_queue.sv]
// Two-entry queue of classified requests between front and back ends.
module jse_queue (
  input  logic               clk,
  input  logic               rst,
  input  jse_pkg::jse_push_t wr,
  input  logic               pop,
  output logic               full,
  output logic               head_valid,
  output jse_pkg::job_t      head
);

  jse_pkg::job_t mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem[wr_ptr] <= wr.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr.push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr.push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[design/jse_back.sv]
// Back end: sends queued text via an output register, one byte per unstalled cycle.
module jse_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  jse_pkg::job_t     head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output jse_pkg::out_req_t out_req
);

  jse_pkg::len_t idx;
  logic          load;
  logic          at_end;

  assign load   = head_valid && (!out_valid || !out_stall);
  assign at_end = (idx == jse_pkg::len_t'(head.len - jse_pkg::len_t'(1)));
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (load) begin
      out_req.out_byte   <= head.text[idx];
      out_req.end_of_run <= at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_end ? '0 : jse_pkg::len_t'(idx + jse_pkg::len_t'(1));
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[design/jse_checker.sv]
// Port-level checks for the JSON string escaper, bound to the top level.
module jse_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input jse_pkg::in_req_t  in_req,
  input logic              out_valid,
  input logic              out_stall,
  input jse_pkg::out_req_t out_req
);

  // stalled output request holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_req))
    else $error("output request changed while stalled");

  // a run never breaks up: its bytes come back to back
  a_run_contig: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_req.end_of_run |=> out_valid)
    else $error("gap inside an output run");

  // an offered output request is fully defined
  a_out_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !$isunknown(out_req))
    else $error("unknown bits in output request");

  // reset empties the block
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("state left after reset");

endmodule

bind json_string_escaper jse_checker u_jse_checker (.*);
